@@ rtl/http_request_header_tokenizer_macros.svh @@
// Assertion macros used by the tokenizer RTL (htok_core).
// No dependencies; included by files that carry concurrent checks.
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_MACROS_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted.
`define HTOK_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off while reset is asserted.
`define HTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/htok_pkg.sv @@
// Types and constants for the HTTP request header tokenizer.
// No dependencies; used by htok_core and the top level.
package htok_pkg;

  typedef enum logic [3:0] {
    ST_START     = 4'd0,
    ST_METHOD    = 4'd1,
    ST_URL_SPACE = 4'd2,
    ST_URL       = 4'd3,
    ST_QUERY     = 4'd4,
    ST_WAIT_VER  = 4'd5,
    ST_VERSION   = 4'd6,
    ST_CR        = 4'd7,
    ST_CL        = 4'd8,
    ST_KEY       = 4'd9,
    ST_KEY_SPACE = 4'd10,
    ST_VALUE     = 4'd11,
    ST_ALMOST    = 4'd12,
    ST_DONE      = 4'd13
  } pstate_t;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_METHOD  = 3'd1,
    KIND_URL     = 3'd2,
    KIND_QUERY   = 3'd3,
    KIND_VERSION = 3'd4,
    KIND_KEY     = 3'd5,
    KIND_VALUE   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    STAT_CONTINUE = 2'd0,
    STAT_COMPLETE = 2'd1,
    STAT_ERROR    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_START = 3'd1,
    ERR_METHOD    = 3'd2,
    ERR_NO_LF     = 3'd3,
    ERR_AFTER_END = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    METH_UNKNOWN = 2'd0,
    METH_GET     = 2'd1,
    METH_POST    = 2'd2
  } method_t;

  localparam logic FUNC_FEED    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [31:0] POST_WORD = 32'h504F_5354;
  localparam logic [23:0] GET_WORD  = 24'h47_4554;
  localparam logic [2:0]  METH_LEN_MAX = 3'd5;
  localparam logic [3:0]  VER_LEN      = 4'd8;
  localparam logic [3:0]  VER_POS_MAX  = 4'd9;

  // "HTTP/1.1"
  localparam logic [7:0] VER_TEXT [8] = '{8'h48, 8'h54, 8'h54, 8'h50,
                                          8'h2F, 8'h31, 8'h2E, 8'h31};

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] byte_kind;
    logic [2:0] token_done;
    logic [1:0] status;
    logic [2:0] error_code;
    logic [1:0] method_code;
    logic       is_http11;
    logic       keep_alive_out;
  } out_t;

endpackage

@@ rtl/htok_core.sv @@
// Parse state registers and the per-byte transition/classification logic.
// Depends on htok_pkg and http_request_header_tokenizer_macros.svh.
`include "http_request_header_tokenizer_macros.svh"

module htok_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  htok_pkg::in_t   item,
  output htok_pkg::out_t  result
);

  htok_pkg::pstate_t st_r, st_nxt;
  logic [31:0]       mchars_r, mchars_nxt;
  logic [2:0]        mlen_r, mlen_nxt;
  logic [3:0]        vpos_r, vpos_nxt;
  logic              vbad_r, vbad_nxt;
  htok_pkg::method_t meth_r, meth_nxt;
  logic              h11_r, h11_nxt;
  logic              ka_r, ka_nxt;

  htok_pkg::kind_t   kind;
  htok_pkg::kind_t   done;
  htok_pkg::status_t status;
  htok_pkg::err_t    err;
  logic [7:0]        ch;
  logic [7:0]        bout;
  logic              push_bad;

  assign ch = item.data_byte;
  // version compare for an ongoing version token
  assign push_bad = (vpos_r >= htok_pkg::VER_LEN) || (ch != htok_pkg::VER_TEXT[vpos_r[2:0]]);

  always_comb begin
    st_nxt     = st_r;
    mchars_nxt = mchars_r;
    mlen_nxt   = mlen_r;
    vpos_nxt   = vpos_r;
    vbad_nxt   = vbad_r;
    meth_nxt   = meth_r;
    h11_nxt    = h11_r;
    ka_nxt     = ka_r;
    kind       = htok_pkg::KIND_NONE;
    done       = htok_pkg::KIND_NONE;
    status     = htok_pkg::STAT_CONTINUE;
    err        = htok_pkg::ERR_NONE;
    bout       = ch;

    if (item.func == htok_pkg::FUNC_RESTART) begin
      st_nxt     = htok_pkg::ST_START;
      mchars_nxt = '0;
      mlen_nxt   = '0;
      vpos_nxt   = '0;
      vbad_nxt   = 1'b0;
      meth_nxt   = htok_pkg::METH_UNKNOWN;
      h11_nxt    = 1'b0;
      ka_nxt     = 1'b0;
      bout       = '0;
    end else begin
      unique case (st_r)
        htok_pkg::ST_START: begin
          if ((ch < htok_pkg::CH_UC_A || ch > htok_pkg::CH_UC_Z) &&
              ch != htok_pkg::CH_UNDER) begin
            err = htok_pkg::ERR_BAD_START;
          end else begin
            kind       = htok_pkg::KIND_METHOD;
            mchars_nxt = {24'd0, ch};
            mlen_nxt   = 3'd1;
            st_nxt     = htok_pkg::ST_METHOD;
          end
        end
        htok_pkg::ST_METHOD: begin
          if (ch == htok_pkg::CH_SPACE) begin
            if (mlen_r == 3'd4 && mchars_r == htok_pkg::POST_WORD) begin
              meth_nxt = htok_pkg::METH_POST;
            end else if (mlen_r == 3'd3 && mchars_r[23:0] == htok_pkg::GET_WORD) begin
              meth_nxt = htok_pkg::METH_GET;
            end else begin
              err = htok_pkg::ERR_METHOD;
            end
            done   = htok_pkg::KIND_METHOD;
            st_nxt = htok_pkg::ST_URL_SPACE;
          end else begin
            kind       = htok_pkg::KIND_METHOD;
            mchars_nxt = {mchars_r[23:0], ch};
            if (mlen_r < htok_pkg::METH_LEN_MAX) begin
              mlen_nxt = mlen_r + 3'd1;
            end
          end
        end
        htok_pkg::ST_URL_SPACE: begin
          if (ch != htok_pkg::CH_SPACE) begin
            kind   = htok_pkg::KIND_URL;
            st_nxt = htok_pkg::ST_URL;
          end
        end
        htok_pkg::ST_URL: begin
          if (ch == htok_pkg::CH_SPACE) begin
            done   = htok_pkg::KIND_URL;
            st_nxt = htok_pkg::ST_WAIT_VER;
          end else if (ch == htok_pkg::CH_QMARK) begin
            done   = htok_pkg::KIND_URL;
            st_nxt = htok_pkg::ST_QUERY;
          end else begin
            kind = htok_pkg::KIND_URL;
          end
        end
        htok_pkg::ST_QUERY: begin
          if (ch == htok_pkg::CH_SPACE) begin
            done   = htok_pkg::KIND_QUERY;
            st_nxt = htok_pkg::ST_WAIT_VER;
          end else begin
            kind = htok_pkg::KIND_QUERY;
          end
        end
        htok_pkg::ST_WAIT_VER: begin
          if (ch != htok_pkg::CH_SPACE) begin
            kind     = htok_pkg::KIND_VERSION;
            vpos_nxt = 4'd1;
            vbad_nxt = (ch != htok_pkg::VER_TEXT[0]);
            st_nxt   = htok_pkg::ST_VERSION;
          end
        end
        htok_pkg::ST_VERSION: begin
          if (ch == htok_pkg::CH_CR) begin
            done    = htok_pkg::KIND_VERSION;
            h11_nxt = !vbad_r && (vpos_r == htok_pkg::VER_LEN);
            if (!vbad_r && (vpos_r == htok_pkg::VER_LEN)) begin
              ka_nxt = 1'b1;
            end
            st_nxt = htok_pkg::ST_CR;
          end else begin
            kind = htok_pkg::KIND_VERSION;
            if (push_bad) begin
              vbad_nxt = 1'b1;
            end
            if (vpos_r < htok_pkg::VER_POS_MAX) begin
              vpos_nxt = vpos_r + 4'd1;
            end
          end
        end
        htok_pkg::ST_CR: begin
          if (ch == htok_pkg::CH_LF) begin
            st_nxt = htok_pkg::ST_CL;
          end else begin
            err = htok_pkg::ERR_NO_LF;
          end
        end
        htok_pkg::ST_CL: begin
          if (ch == htok_pkg::CH_CR) begin
            st_nxt = htok_pkg::ST_ALMOST;
          end else begin
            kind   = htok_pkg::KIND_KEY;
            st_nxt = htok_pkg::ST_KEY;
          end
        end
        htok_pkg::ST_KEY: begin
          if (ch == htok_pkg::CH_COLON) begin
            done   = htok_pkg::KIND_KEY;
            st_nxt = htok_pkg::ST_KEY_SPACE;
          end else begin
            kind = htok_pkg::KIND_KEY;
          end
        end
        htok_pkg::ST_KEY_SPACE: begin
          if (ch != htok_pkg::CH_SPACE) begin
            kind   = htok_pkg::KIND_VALUE;
            st_nxt = htok_pkg::ST_VALUE;
          end
        end
        htok_pkg::ST_VALUE: begin
          if (ch == htok_pkg::CH_CR) begin
            done   = htok_pkg::KIND_VALUE;
            st_nxt = htok_pkg::ST_CR;
          end else begin
            kind = htok_pkg::KIND_VALUE;
          end
        end
        htok_pkg::ST_ALMOST: begin
          if (ch == htok_pkg::CH_LF) begin
            st_nxt = htok_pkg::ST_DONE;
            status = htok_pkg::STAT_COMPLETE;
          end
        end
        default: begin
          err = htok_pkg::ERR_AFTER_END;
        end
      endcase

      // an error leaves every piece of state as it was
      if (err != htok_pkg::ERR_NONE) begin
        st_nxt     = st_r;
        mchars_nxt = mchars_r;
        mlen_nxt   = mlen_r;
        vpos_nxt   = vpos_r;
        vbad_nxt   = vbad_r;
        meth_nxt   = meth_r;
        h11_nxt    = h11_r;
        ka_nxt     = ka_r;
        status     = htok_pkg::STAT_ERROR;
        kind       = htok_pkg::KIND_NONE;
        done       = htok_pkg::KIND_NONE;
      end

      if (kind == htok_pkg::KIND_KEY && ch >= htok_pkg::CH_UC_A && ch <= htok_pkg::CH_UC_Z) begin
        bout = ch | htok_pkg::CASE_BIT;
      end
    end
  end

  always_comb begin
    result.byte_out       = bout;
    result.byte_kind      = kind;
    result.token_done     = done;
    result.status         = status;
    result.error_code     = err;
    result.method_code    = meth_nxt;
    result.is_http11      = h11_nxt;
    result.keep_alive_out = ka_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= htok_pkg::ST_START;
      mchars_r <= '0;
      mlen_r   <= '0;
      vpos_r   <= '0;
      vbad_r   <= 1'b0;
      meth_r   <= htok_pkg::METH_UNKNOWN;
      h11_r    <= 1'b0;
      ka_r     <= 1'b0;
    end else if (fire) begin
      st_r     <= st_nxt;
      mchars_r <= mchars_nxt;
      mlen_r   <= mlen_nxt;
      vpos_r   <= vpos_nxt;
      vbad_r   <= vbad_nxt;
      meth_r   <= meth_nxt;
      h11_r    <= h11_nxt;
      ka_r     <= ka_nxt;
    end
  end

  `HTOK_ASSERT_NEXT(a_err_holds_state, clk, rst_n,
    fire && result.status == htok_pkg::STAT_ERROR, st_r == $past(st_r) && mchars_r == $past(mchars_r),
    "error transfer changed parse state")
  `HTOK_ASSERT_NEXT(a_restart_clears, clk, rst_n,
    fire && item.func == htok_pkg::FUNC_RESTART, st_r == htok_pkg::ST_START && !ka_r && !h11_r,
    "restart did not return to request start")
  `HTOK_ASSERT_SAME(a_complete_from_almost, clk, rst_n,
    fire && result.status == htok_pkg::STAT_COMPLETE, st_r == htok_pkg::ST_ALMOST,
    "head complete reported outside blank-line state")
  `HTOK_ASSERT_NEXT(a_keepalive_sticky, clk, rst_n,
    ka_r && !(fire && item.func == htok_pkg::FUNC_RESTART), ka_r,
    "keep-alive dropped without restart")

endmodule

@@ rtl/http_request_header_tokenizer.sv @@
// HTTP request header tokenizer, top level: input stage, parse core, result register.
// Depends on htok_pkg and htok_core.
//
// Byte-streaming tokenizer for an HTTP request head. Each transfer on the input
// channel is either one request byte (func = 0) or a restart (func = 1), and
// produces exactly one result transfer: the byte (lower-cased inside header keys),
// its token kind, the kind of token it closed, a status (continue, head complete,
// error), an error code, and the method / HTTP/1.1 / keep-alive flags as they stand
// after that byte. An erroneous byte changes no parse state, so it can be resent.
// Once the head is complete every byte is refused until a restart. Throughput is one
// byte per clock while out_ready is high: a byte is registered in the input stage,
// the parse state is updated as it moves into the result register, and the result
// is driven from that register. The only thing that throttles intake is out_ready;
// in_ready depends combinationally on it through the two-entry pipeline.
module http_request_header_tokenizer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  htok_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output htok_pkg::out_t  out_data
);

  // input stage
  logic           s1_valid_r, s1_valid_nxt;
  htok_pkg::in_t  s1_item_r;

  // result register
  logic           out_valid_r, out_valid_nxt;
  htok_pkg::out_t out_data_r;

  htok_pkg::out_t core_result;
  logic           advance;

  // stage 1 hands its byte to the core when the result slot is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  htok_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (s1_item_r),
    .result (core_result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_data_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
